### rtl/dsfp_pkg.sv
// Shared types and constants for the direction sector quantizer.
`default_nettype none
package dsfp_pkg;

    // Sector boundaries inside one quadrant lie at 8, 23, 38, 53, 68 and 83 degrees.
    localparam int NUM_BOUND        = 6;
    localparam int SECTORS_PER_QUAD = 6;
    localparam int NUM_SECTORS      = 24;
    localparam int SECTOR_W         = 5;
    localparam int COUNT_W          = 3;

    // Boundary tangents in units of 1e-12, split into a high and a low part.
    localparam int TAN_W = 43;
    localparam int TL_W  = 22;
    localparam int TH_W  = TAN_W - TL_W;

    localparam logic [TAN_W-1:0] BOUND_TAN [NUM_BOUND] = '{
        43'd140540834702,
        43'd424474816210,
        43'd781285626507,
        43'd1327044821620,
        43'd2475086853416,
        43'd8144346427975
    };

    // 1e12 = 5^12 * 2^12
    localparam int               SCALE_ODD_W = 28;
    localparam logic [SCALE_ODD_W-1:0] SCALE_ODD = 28'd244140625;
    localparam int               SCALE_SHIFT = 12;

    typedef logic [1:0]          t_quad;
    typedef logic [COUNT_W-1:0]  t_count;
    typedef logic [SECTOR_W-1:0] t_sector;

    localparam t_quad QUAD_0 = 2'd0;
    localparam t_quad QUAD_1 = 2'd1;
    localparam t_quad QUAD_2 = 2'd2;
    localparam t_quad QUAD_3 = 2'd3;

    localparam t_sector SECTOR_NONE = 5'd0;

endpackage
`default_nettype wire

### rtl/dsfp_if.sv
// Point-pair and sector channel interfaces.
`default_nettype none
interface dsfp_pt_if #(parameter int COORD_BITS = 8);
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] src_x;
    logic signed [COORD_BITS-1:0] src_y;
    logic signed [COORD_BITS-1:0] dst_x;
    logic signed [COORD_BITS-1:0] dst_y;

    modport source (output valid, output src_x, output src_y, output dst_x,
                    output dst_y, input ready);
    modport sink   (input valid, input src_x, input src_y, input dst_x,
                    input dst_y, output ready);
endinterface

interface dsfp_sec_if;
    logic                 valid;
    logic                 ready;
    dsfp_pkg::t_sector    sector;

    modport source (output valid, output sector, input ready);
    modport sink   (input valid, input sector, output ready);
endinterface
`default_nettype wire

### rtl/dsfp_fold.sv
// Difference vector and quarter-turn fold into the first quadrant.
`default_nettype none
module dsfp_fold #(
    parameter int COORD_BITS = 8
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic signed [COORD_BITS-1:0] i_src_x,
    input  logic signed [COORD_BITS-1:0] i_src_y,
    input  logic signed [COORD_BITS-1:0] i_dst_x,
    input  logic signed [COORD_BITS-1:0] i_dst_y,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [COORD_BITS-1:0]        o_a,
    output logic [COORD_BITS-1:0]        o_b,
    output dsfp_pkg::t_quad              o_quad,
    output logic                         o_zero
);
    import dsfp_pkg::*;

    localparam int DW = COORD_BITS + 1;

    logic signed [DW-1:0]  dx, dy, ndx, ndy;
    logic                  dx_neg, dy_neg, dx_nz, dy_nz;
    logic [COORD_BITS-1:0] n_a, n_b;
    t_quad                 n_quad;

    logic                  r_v;
    logic [COORD_BITS-1:0] r_a, r_b;
    t_quad                 r_quad;
    logic                  r_zero;

    assign dx  = DW'(i_src_x) - DW'(i_dst_x);
    assign dy  = DW'(i_dst_y) - DW'(i_src_y);
    assign ndx = -dx;
    assign ndy = -dy;

    assign dx_neg = dx[DW-1];
    assign dy_neg = dy[DW-1];
    assign dx_nz  = (dx != '0);
    assign dy_nz  = (dy != '0);

    // Rotate by quarter turns until dx >= 0 and dy > 0.
    always_comb begin
        if (!dx_neg && dy_nz && !dy_neg) begin
            n_quad = QUAD_0;
            n_a    = dx[COORD_BITS-1:0];
            n_b    = dy[COORD_BITS-1:0];
        end else if ((dy_neg || !dy_nz) && dx_nz && !dx_neg) begin
            n_quad = QUAD_1;
            n_a    = ndy[COORD_BITS-1:0];
            n_b    = dx[COORD_BITS-1:0];
        end else if ((dx_neg || !dx_nz) && dy_neg) begin
            n_quad = QUAD_2;
            n_a    = ndx[COORD_BITS-1:0];
            n_b    = ndy[COORD_BITS-1:0];
        end else begin
            n_quad = QUAD_3;
            n_a    = dy[COORD_BITS-1:0];
            n_b    = ndx[COORD_BITS-1:0];
        end
    end

    assign o_ready = !r_v || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (o_ready) begin
            r_v <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_a    <= n_a;
            r_b    <= n_b;
            r_quad <= n_quad;
            r_zero <= !dx_nz && !dy_nz;
        end
    end

    assign o_valid = r_v;
    assign o_a     = r_a;
    assign o_b     = r_b;
    assign o_quad  = r_quad;
    assign o_zero  = r_zero;

endmodule
`default_nettype wire

### rtl/dsfp_mult.sv
// Two-stage constant products against the boundary tangents.
`default_nettype none
module dsfp_mult #(
    parameter int COORD_BITS = 8
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_ready,
    input  logic [COORD_BITS-1:0]  i_a,
    input  logic [COORD_BITS-1:0]  i_b,
    input  dsfp_pkg::t_quad        i_quad,
    input  logic                   i_zero,
    output logic                   o_valid,
    input  logic                   i_ready,
    output logic [COORD_BITS+dsfp_pkg::SCALE_ODD_W-1:0] o_lhs,
    output logic [COORD_BITS+dsfp_pkg::TL_W-1:0]        o_pl [dsfp_pkg::NUM_BOUND],
    output logic [COORD_BITS+dsfp_pkg::TH_W-1:0]        o_ph [dsfp_pkg::NUM_BOUND],
    output dsfp_pkg::t_quad        o_quad,
    output logic                   o_zero
);
    import dsfp_pkg::*;

    localparam int LW  = COORD_BITS + SCALE_ODD_W;
    localparam int PLW = COORD_BITS + TL_W;
    localparam int PHW = COORD_BITS + TH_W;

    logic                  adv2, adv3;

    // Stage 2: odd part of the scale on a, low tangent parts on b.
    logic                  r_s2_v;
    logic [LW-1:0]         r_s2_lhs;
    logic [PLW-1:0]        r_s2_pl [NUM_BOUND];
    logic [COORD_BITS-1:0] r_s2_b;
    t_quad                 r_s2_quad;
    logic                  r_s2_zero;

    // Stage 3: high tangent parts on b.
    logic                  r_s3_v;
    logic [LW-1:0]         r_s3_lhs;
    logic [PLW-1:0]        r_s3_pl [NUM_BOUND];
    logic [PHW-1:0]        r_s3_ph [NUM_BOUND];
    t_quad                 r_s3_quad;
    logic                  r_s3_zero;

    logic [LW-1:0]         n_s2_lhs;
    logic [PLW-1:0]        n_s2_pl [NUM_BOUND];
    logic [PHW-1:0]        n_s3_ph [NUM_BOUND];

    assign adv3    = !r_s3_v || i_ready;
    assign adv2    = !r_s2_v || adv3;
    assign o_ready = adv2;

    always_comb begin
        n_s2_lhs = LW'(i_a) * LW'(SCALE_ODD);
        for (int k = 0; k < NUM_BOUND; k++) begin
            n_s2_pl[k] = PLW'(i_b) * PLW'(BOUND_TAN[k][TL_W-1:0]);
            n_s3_ph[k] = PHW'(r_s2_b) * PHW'(BOUND_TAN[k][TAN_W-1:TL_W]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_v <= 1'b0;
            r_s3_v <= 1'b0;
        end else begin
            if (adv2) begin
                r_s2_v <= i_valid;
            end
            if (adv3) begin
                r_s3_v <= r_s2_v;
            end
        end
        if (adv2 && i_valid) begin
            r_s2_lhs  <= n_s2_lhs;
            r_s2_pl   <= n_s2_pl;
            r_s2_b    <= i_b;
            r_s2_quad <= i_quad;
            r_s2_zero <= i_zero;
        end
        if (adv3 && r_s2_v) begin
            r_s3_lhs  <= r_s2_lhs;
            r_s3_pl   <= r_s2_pl;
            r_s3_ph   <= n_s3_ph;
            r_s3_quad <= r_s2_quad;
            r_s3_zero <= r_s2_zero;
        end
    end

    assign o_valid = r_s3_v;
    assign o_lhs   = r_s3_lhs;
    assign o_pl    = r_s3_pl;
    assign o_ph    = r_s3_ph;
    assign o_quad  = r_s3_quad;
    assign o_zero  = r_s3_zero;

endmodule
`default_nettype wire

### rtl/dsfp_sector.sv
// Boundary compare, crossing count and sector output register.
`default_nettype none
module dsfp_sector #(
    parameter int COORD_BITS = 8
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_ready,
    input  logic [COORD_BITS+dsfp_pkg::SCALE_ODD_W-1:0] i_lhs,
    input  logic [COORD_BITS+dsfp_pkg::TL_W-1:0]        i_pl [dsfp_pkg::NUM_BOUND],
    input  logic [COORD_BITS+dsfp_pkg::TH_W-1:0]        i_ph [dsfp_pkg::NUM_BOUND],
    input  dsfp_pkg::t_quad        i_quad,
    input  logic                   i_zero,
    output logic                   o_valid,
    input  logic                   i_ready,
    output dsfp_pkg::t_sector      o_sector
);
    import dsfp_pkg::*;

    localparam int CW = COORD_BITS + TAN_W + 1;

    logic [CW-1:0] lhs;
    logic [CW-1:0] rhs [NUM_BOUND];
    t_count        count;
    t_sector       sum, wrapped, n_sector;

    logic          r_v;
    t_sector       r_sector;

    // a * 1e12 > b * tan, with both sides rebuilt from their partial products.
    always_comb begin
        lhs   = CW'(i_lhs) << SCALE_SHIFT;
        count = '0;
        for (int k = 0; k < NUM_BOUND; k++) begin
            rhs[k] = (CW'(i_ph[k]) << TL_W) + CW'(i_pl[k]);
            count  = count + COUNT_W'(lhs > rhs[k]);
        end
        sum     = SECTOR_W'(i_quad) * SECTOR_W'(SECTORS_PER_QUAD) + SECTOR_W'(count);
        // Only the last crossing of the fourth quadrant reaches a full turn.
        wrapped = (sum == SECTOR_W'(NUM_SECTORS)) ? '0 : sum;
        n_sector = i_zero ? SECTOR_NONE : wrapped + SECTOR_W'(1);
    end

    assign o_ready = !r_v || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (o_ready) begin
            r_v <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_sector <= n_sector;
        end
    end

    assign o_valid  = r_v;
    assign o_sector = r_sector;

endmodule
`default_nettype wire

### rtl/direction_sector_from_points.sv
// Top level: facing sector 1..24 of the direction between two points, 0 if they coincide.
// Four stages: fold, low products, high products, compare and count.
// Throughput: one point pair per cycle while results are taken; a stage refills as soon as it empties.
// Reset clears the stage valid bits only; no clearing pass, no state.
`default_nettype none
module direction_sector_from_points #(
    parameter int COORD_BITS = 8
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    dsfp_pt_if.sink         i_pt,
    dsfp_sec_if.source      o_sec
);
    import dsfp_pkg::*;

    // Fold stage to multiply stages.
    logic                  w_fold_valid, w_fold_ready;
    logic [COORD_BITS-1:0] w_a, w_b;
    t_quad                 w_fold_quad;
    logic                  w_fold_zero;

    // Multiply stages to compare stage.
    logic                  w_mul_valid, w_mul_ready;
    logic [COORD_BITS+SCALE_ODD_W-1:0] w_lhs;
    logic [COORD_BITS+TL_W-1:0]        w_pl [NUM_BOUND];
    logic [COORD_BITS+TH_W-1:0]        w_ph [NUM_BOUND];
    t_quad                 w_mul_quad;
    logic                  w_mul_zero;

    // Difference vector, turned into dx >= 0, dy > 0 with its quarter-turn count.
    dsfp_fold #(.COORD_BITS(COORD_BITS)) u_fold (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_pt.valid),
        .o_ready (i_pt.ready),
        .i_src_x (i_pt.src_x),
        .i_src_y (i_pt.src_y),
        .i_dst_x (i_pt.dst_x),
        .i_dst_y (i_pt.dst_y),
        .o_valid (w_fold_valid),
        .i_ready (w_fold_ready),
        .o_a     (w_a),
        .o_b     (w_b),
        .o_quad  (w_fold_quad),
        .o_zero  (w_fold_zero)
    );

    // Exact products against the boundary tangents, split over two stages.
    dsfp_mult #(.COORD_BITS(COORD_BITS)) u_mult (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_fold_valid),
        .o_ready (w_fold_ready),
        .i_a     (w_a),
        .i_b     (w_b),
        .i_quad  (w_fold_quad),
        .i_zero  (w_fold_zero),
        .o_valid (w_mul_valid),
        .i_ready (w_mul_ready),
        .o_lhs   (w_lhs),
        .o_pl    (w_pl),
        .o_ph    (w_ph),
        .o_quad  (w_mul_quad),
        .o_zero  (w_mul_zero)
    );

    // Count crossed boundaries, add six per quarter turn, wrap, hold until taken.
    dsfp_sector #(.COORD_BITS(COORD_BITS)) u_sector (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (w_mul_valid),
        .o_ready  (w_mul_ready),
        .i_lhs    (w_lhs),
        .i_pl     (w_pl),
        .i_ph     (w_ph),
        .i_quad   (w_mul_quad),
        .i_zero   (w_mul_zero),
        .o_valid  (o_sec.valid),
        .i_ready  (o_sec.ready),
        .o_sector (o_sec.sector)
    );

`ifndef SYNTHESIS
    // A sector never leaves the 0..24 range.
    a_sector_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_sec.valid |-> (o_sec.sector <= SECTOR_W'(NUM_SECTORS)))
        else $error("sector out of range");

    // Input backpressure only comes from a stalled result at the output.
    a_stall_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_pt.ready |-> (o_sec.valid && !o_sec.ready))
        else $error("input stalled without an output stall");

    // A new result only appears after the multiply stages held an item.
    a_result_origin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_sec.valid) |-> $past(w_mul_valid))
        else $error("result without a preceding item");
`endif

endmodule
`default_nettype wire
